// File: rtl/core/bpa_pkg.sv
// shared types, constants and helper functions of the buddy page allocator
package bpa_pkg;

  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned MAX_ORDERS = 11;

  localparam int unsigned FRAME_W  = 10;
  localparam int unsigned ORD_W    = 4;
  localparam int unsigned REF_W    = 8;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned ST_DEPTH = MAX_ORDERS * MAX_FRAMES;
  localparam int unsigned ST_AW    = $clog2(ST_DEPTH);

  // request modes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_ADDREF  = 2'd2;
  localparam logic [1:0] MODE_DROPREF = 2'd3;

  // configuration register indexes
  localparam logic CFG_FRAME_COUNT  = 1'b0;
  localparam logic CFG_ORDER_LEVELS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OOM      = 3'd1,
    ST_IS_FREE  = 3'd2,
    ST_NOT_HEAD = 3'd3,
    ST_REFD     = 3'd4,
    ST_RANGE    = 3'd5
  } status_t;

  // one frame table entry
  typedef struct packed {
    logic             used;
    logic             cont;
    logic [ORD_W-1:0] ord;
    logic [REF_W-1:0] refs;
  } frame_t;

  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] addr;
    frame_t             data;
  } fr_wr_t;

  typedef struct packed {
    logic               en;
    logic [ST_AW-1:0]   addr;
    logic [FRAME_W-1:0] data;
  } st_wr_t;

  // flat address of a free stack slot
  function automatic logic [ST_AW-1:0] st_addr(input logic [ORD_W-1:0] ord,
                                               input logic [FRAME_W-1:0] idx);
    st_addr = ST_AW'(ord) * ST_AW'(MAX_FRAMES) + ST_AW'(idx);
  endfunction

  // index of the highest set bit, zero for zero
  function automatic logic [ORD_W-1:0] msb_index(input logic [CNT_W-1:0] v);
    msb_index = '0;
    for (int k = 0; k < CNT_W; k++) begin
      if (v[k]) msb_index = ORD_W'(k);
    end
  endfunction

  // trailing zero count, full width for zero
  function automatic logic [ORD_W-1:0] tz_count(input logic [FRAME_W-1:0] v);
    tz_count = ORD_W'(FRAME_W);
    for (int k = FRAME_W - 1; k >= 0; k--) begin
      if (v[k]) tz_count = ORD_W'(k);
    end
  endfunction

endpackage

// File: rtl/core/bpa_frame_ram.sv
// frame table memory, one write port and one registered read port
module bpa_frame_ram (
  input  logic                         clk,
  input  bpa_pkg::fr_wr_t              wr,
  input  logic [bpa_pkg::FRAME_W-1:0]  rd_addr,
  output bpa_pkg::frame_t              rd_data
);

  bpa_pkg::frame_t mem [bpa_pkg::MAX_FRAMES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/bpa_stack_ram.sv
// free stack memory holding every order's stack of block heads
module bpa_stack_ram (
  input  logic                         clk,
  input  bpa_pkg::st_wr_t              wr,
  input  logic [bpa_pkg::ST_AW-1:0]    rd_addr,
  output logic [bpa_pkg::FRAME_W-1:0]  rd_data
);

  logic [bpa_pkg::FRAME_W-1:0] mem [bpa_pkg::ST_DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/buddy_page_allocator_top.sv
// buddy page allocator: request sequencer over frame table and free stacks
//
// One request at a time: a beat is taken when start is high and busy is low,
// and its single result beat shows on the out_ ports for one cycle with
// out_valid high; the receiver cannot stall it. After reset and after every
// configuration write the block rebuilds its tables in a sweep over all
// 1024 frames with busy high. Timing is set by the frame table port, one
// frame per cycle when marking a block, and by the free stack port. Alloc
// time grows with each split order and with the size of the allocated
// block; add and drop reference walk every frame of the block; free time
// grows with the final block, with the stack depth searched at each merge
// step and with a buddy that is looked up but cannot be merged. Errors
// return without touching the tables.
module buddy_page_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [3:0]                    in_block_order,
  input  logic [9:0]                    in_frame_number,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [9:0]                    out_result_frame,
  output logic [3:0]                    out_result_order,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [10:0]                   cfg_wr_data
);

  localparam int unsigned FW = bpa_pkg::FRAME_W;
  localparam int unsigned OW = bpa_pkg::ORD_W;
  localparam int unsigned CW = bpa_pkg::CNT_W;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_INIT      = 17'h00002,
    S_FIND      = 17'h00004,
    S_POP       = 17'h00008,
    S_SPLIT     = 17'h00010,
    S_MARK      = 17'h00020,
    S_CHK       = 17'h00040,
    S_REF_RD    = 17'h00080,
    S_REF_WR    = 17'h00100,
    S_MRG       = 17'h00200,
    S_BUD_CHK   = 17'h00400,
    S_SRCH_RD   = 17'h00800,
    S_SRCH_CMP  = 17'h01000,
    S_SHF_RD    = 17'h02000,
    S_SHF_WR    = 17'h04000,
    S_FREE_PUSH = 17'h08000,
    S_DONE      = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [OW-1:0]  req_r, req_nxt;
  logic [FW-1:0]  fr_r, fr_nxt;
  logic [FW-1:0]  head_r, head_nxt;
  logic [OW-1:0]  ord_r, ord_nxt;
  logic [OW-1:0]  s_r, s_nxt;
  logic [FW-1:0]  buddy_r, buddy_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [FW-1:0]  mark_base_r, mark_base_nxt;
  logic [CW-1:0]  mark_n_r, mark_n_nxt;
  logic [OW-1:0]  mark_ord_r, mark_ord_nxt;
  logic           mark_used_r, mark_used_nxt;
  logic [7:0]     mark_refs_r, mark_refs_nxt;
  logic           mark_last_r, mark_last_nxt;
  bpa_pkg::status_t status_r, status_nxt;
  logic [FW-1:0]  res_frame_r, res_frame_nxt;
  logic [OW-1:0]  res_ord_r, res_ord_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  fc_r, fc_nxt;
  logic [OW-1:0]  ol_r, ol_nxt;
  logic [CW-1:0]  blk_end_r, blk_end_nxt;
  logic [OW-1:0]  blk_ord_r, blk_ord_nxt;
  logic [CW-1:0]  depth_r [bpa_pkg::MAX_ORDERS];

  logic           depth_clr;
  logic           d_we;
  logic [OW-1:0]  d_idx;
  logic [CW-1:0]  d_wdata;
  logic [CW-1:0]  dsel;

  bpa_pkg::fr_wr_t  fr_wr;
  logic [FW-1:0]    fr_raddr;
  bpa_pkg::frame_t  fr_rdata;
  bpa_pkg::st_wr_t  st_wr;
  logic [bpa_pkg::ST_AW-1:0] st_raddr;
  logic [FW-1:0]    st_rdata;

  logic [CW-1:0]  fc_eff;
  logic [OW-1:0]  lv_eff;
  logic           find_ok;
  logic [OW-1:0]  find_s;
  logic [OW-1:0]  init_o;
  logic [CW-1:0]  init_rem;

  bpa_frame_ram u_frame_ram (
    .clk     (clk),
    .wr      (fr_wr),
    .rd_addr (fr_raddr),
    .rd_data (fr_rdata)
  );

  bpa_stack_ram u_stack_ram (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  // effective configuration
  always_comb begin
    if (fc_r > CW'(bpa_pkg::MAX_FRAMES)) fc_eff = CW'(bpa_pkg::MAX_FRAMES);
    else fc_eff = fc_r;
    if (ol_r == '0) lv_eff = OW'(1);
    else if (ol_r > OW'(bpa_pkg::MAX_ORDERS)) lv_eff = OW'(bpa_pkg::MAX_ORDERS);
    else lv_eff = ol_r;
  end

  // smallest non-empty order at or above the request
  always_comb begin
    find_ok = 1'b0;
    find_s  = '0;
    for (int k = 0; k < bpa_pkg::MAX_ORDERS; k++) begin
      if (!find_ok && OW'(k) >= req_r && OW'(k) < lv_eff && depth_r[k] != '0) begin
        find_ok = 1'b1;
        find_s  = OW'(k);
      end
    end
  end

  // order of the initial block starting at the sweep frame
  always_comb begin
    init_rem = fc_eff - cnt_r;
    init_o   = bpa_pkg::msb_index(init_rem);
    if (init_o > lv_eff - OW'(1)) init_o = lv_eff - OW'(1);
    if (init_o > bpa_pkg::tz_count(cnt_r[FW-1:0])) init_o = bpa_pkg::tz_count(cnt_r[FW-1:0]);
  end

  // stack depth select
  always_comb begin
    case (state_r)
      S_INIT:  d_idx = init_o;
      S_FIND:  d_idx = find_s;
      S_SPLIT: d_idx = s_r - OW'(1);
      default: d_idx = ord_r;
    endcase
    dsel = depth_r[d_idx];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    req_nxt       = req_r;
    fr_nxt        = fr_r;
    head_nxt      = head_r;
    ord_nxt       = ord_r;
    s_nxt         = s_r;
    buddy_nxt     = buddy_r;
    cnt_nxt       = cnt_r;
    mark_base_nxt = mark_base_r;
    mark_n_nxt    = mark_n_r;
    mark_ord_nxt  = mark_ord_r;
    mark_used_nxt = mark_used_r;
    mark_refs_nxt = mark_refs_r;
    mark_last_nxt = mark_last_r;
    status_nxt    = status_r;
    res_frame_nxt = res_frame_r;
    res_ord_nxt   = res_ord_r;
    out_valid_nxt = 1'b0;
    fc_nxt        = fc_r;
    ol_nxt        = ol_r;
    blk_end_nxt   = blk_end_r;
    blk_ord_nxt   = blk_ord_r;
    depth_clr     = 1'b0;
    d_we          = 1'b0;
    d_wdata       = dsel;
    fr_wr         = '0;
    fr_raddr      = fr_r;
    st_wr         = '0;
    st_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        fr_raddr = in_frame_number;
        if (start) begin
          mode_nxt      = in_mode;
          req_nxt       = in_block_order;
          fr_nxt        = in_frame_number;
          res_frame_nxt = '0;
          res_ord_nxt   = '0;
          if (in_mode == bpa_pkg::MODE_ALLOC) begin
            if (in_block_order >= lv_eff) begin
              status_nxt = bpa_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FIND;
            end
          end else if ({1'b0, in_frame_number} >= fc_eff) begin
            status_nxt = bpa_pkg::ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end

      // rebuild sweep, one frame per cycle
      S_INIT: begin
        fr_wr.en   = 1'b1;
        fr_wr.addr = cnt_r[FW-1:0];
        fr_wr.data = '0;
        if (cnt_r < fc_eff) begin
          if (cnt_r == blk_end_r) begin
            if (dsel < CW'(bpa_pkg::MAX_FRAMES)) begin
              st_wr.en   = 1'b1;
              st_wr.addr = bpa_pkg::st_addr(init_o, dsel[FW-1:0]);
              st_wr.data = cnt_r[FW-1:0];
              d_we       = 1'b1;
              d_wdata    = dsel + CW'(1);
            end
            fr_wr.data.ord = init_o;
            blk_ord_nxt    = init_o;
            blk_end_nxt    = cnt_r + (CW'(1) << init_o);
          end else begin
            fr_wr.data.cont = 1'b1;
            fr_wr.data.ord  = blk_ord_r;
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(bpa_pkg::MAX_FRAMES - 1)) state_nxt = S_IDLE;
      end

      // pop the smallest fitting block
      S_FIND: begin
        if (!find_ok) begin
          status_nxt = bpa_pkg::ST_OOM;
          state_nxt  = S_DONE;
        end else begin
          d_we      = 1'b1;
          d_wdata   = dsel - CW'(1);
          st_raddr  = bpa_pkg::st_addr(find_s, FW'(dsel - CW'(1)));
          s_nxt     = find_s;
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        head_nxt  = st_rdata;
        state_nxt = S_SPLIT;
      end

      // push upper halves back and mark them free, then mark the allocated block
      S_SPLIT: begin
        cnt_nxt   = '0;
        state_nxt = S_MARK;
        if (s_r > req_r) begin
          if (dsel < CW'(bpa_pkg::MAX_FRAMES)) begin
            st_wr.en   = 1'b1;
            st_wr.addr = bpa_pkg::st_addr(d_idx, dsel[FW-1:0]);
            st_wr.data = head_r + FW'(CW'(1) << d_idx);
            d_we       = 1'b1;
            d_wdata    = dsel + CW'(1);
          end
          s_nxt         = d_idx;
          mark_base_nxt = head_r + FW'(CW'(1) << d_idx);
          mark_n_nxt    = CW'(1) << d_idx;
          mark_ord_nxt  = d_idx;
          mark_used_nxt = 1'b0;
          mark_refs_nxt = '0;
          mark_last_nxt = 1'b0;
        end else begin
          mark_base_nxt = head_r;
          mark_n_nxt    = CW'(1) << req_r;
          mark_ord_nxt  = req_r;
          mark_used_nxt = 1'b1;
          mark_refs_nxt = 8'd1;
          mark_last_nxt = 1'b1;
          status_nxt    = bpa_pkg::ST_OK;
          res_frame_nxt = head_r;
          res_ord_nxt   = req_r;
        end
      end

      // write the frames of one block
      S_MARK: begin
        if (cnt_r == mark_n_r ||
            ({2'b0, mark_base_r} + {1'b0, cnt_r}) >= (CW + 1)'(bpa_pkg::MAX_FRAMES)) begin
          state_nxt = mark_last_r ? S_DONE : S_SPLIT;
        end else begin
          fr_wr.en        = 1'b1;
          fr_wr.addr      = mark_base_r + cnt_r[FW-1:0];
          fr_wr.data.used = mark_used_r;
          fr_wr.data.cont = (cnt_r != '0);
          fr_wr.data.ord  = mark_ord_r;
          fr_wr.data.refs = mark_refs_r;
          cnt_nxt         = cnt_r + CW'(1);
        end
      end

      // head checks for free and reference requests
      S_CHK: begin
        if (!fr_rdata.used) begin
          status_nxt = bpa_pkg::ST_IS_FREE;
          state_nxt  = S_DONE;
        end else if (fr_rdata.cont) begin
          status_nxt = bpa_pkg::ST_NOT_HEAD;
          state_nxt  = S_DONE;
        end else if (mode_r == bpa_pkg::MODE_FREE && fr_rdata.refs > 8'd1) begin
          status_nxt = bpa_pkg::ST_REFD;
          state_nxt  = S_DONE;
        end else if (mode_r == bpa_pkg::MODE_ADDREF ||
                     (mode_r == bpa_pkg::MODE_DROPREF && fr_rdata.refs > 8'd1)) begin
          mark_n_nxt    = CW'(1) << fr_rdata.ord;
          cnt_nxt       = '0;
          status_nxt    = bpa_pkg::ST_OK;
          res_frame_nxt = fr_r;
          res_ord_nxt   = fr_rdata.ord;
          state_nxt     = S_REF_RD;
        end else begin
          head_nxt  = fr_r;
          ord_nxt   = fr_rdata.ord;
          state_nxt = S_MRG;
        end
      end

      // reference count read-modify-write, a read step and a write step per frame
      S_REF_RD: begin
        fr_raddr = fr_r + cnt_r[FW-1:0];
        if (cnt_r == mark_n_r ||
            ({2'b0, fr_r} + {1'b0, cnt_r}) >= (CW + 1)'(bpa_pkg::MAX_FRAMES)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_REF_WR;
        end
      end

      S_REF_WR: begin
        fr_wr.en   = 1'b1;
        fr_wr.addr = fr_r + cnt_r[FW-1:0];
        fr_wr.data = fr_rdata;
        if (mode_r == bpa_pkg::MODE_ADDREF) begin
          if (fr_rdata.refs != 8'hff) fr_wr.data.refs = fr_rdata.refs + 8'd1;
        end else begin
          if (fr_rdata.refs != 8'h00) fr_wr.data.refs = fr_rdata.refs - 8'd1;
        end
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_REF_RD;
      end

      // next merge step: look up the buddy
      S_MRG: begin
        buddy_nxt = head_r ^ FW'(CW'(1) << ord_r);
        fr_raddr  = head_r ^ FW'(CW'(1) << ord_r);
        if (({1'b0, ord_r} + (OW + 1)'(1)) < {1'b0, lv_eff} &&
            {1'b0, head_r ^ FW'(CW'(1) << ord_r)} < fc_eff) begin
          state_nxt = S_BUD_CHK;
        end else begin
          state_nxt = S_FREE_PUSH;
        end
      end

      S_BUD_CHK: begin
        cnt_nxt = '0;
        if (fr_rdata.used || fr_rdata.cont || fr_rdata.ord != ord_r) begin
          state_nxt = S_FREE_PUSH;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end

      // search the buddy in its stack
      S_SRCH_RD: begin
        st_raddr = bpa_pkg::st_addr(ord_r, cnt_r[FW-1:0]);
        if (cnt_r >= dsel) state_nxt = S_FREE_PUSH;
        else state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        cnt_nxt = cnt_r + CW'(1);
        if (st_rdata == buddy_r) state_nxt = S_SHF_RD;
        else state_nxt = S_SRCH_RD;
      end

      // close the gap left by the removed entry
      S_SHF_RD: begin
        st_raddr = bpa_pkg::st_addr(ord_r, cnt_r[FW-1:0]);
        if (cnt_r >= dsel) begin
          d_we      = 1'b1;
          d_wdata   = dsel - CW'(1);
          if (buddy_r < head_r) head_nxt = buddy_r;
          ord_nxt   = ord_r + OW'(1);
          state_nxt = S_MRG;
        end else begin
          state_nxt = S_SHF_WR;
        end
      end

      S_SHF_WR: begin
        st_wr.en   = 1'b1;
        st_wr.addr = bpa_pkg::st_addr(ord_r, FW'(cnt_r - CW'(1)));
        st_wr.data = st_rdata;
        cnt_nxt    = cnt_r + CW'(1);
        state_nxt  = S_SHF_RD;
      end

      // push the merged block and clear its frames
      S_FREE_PUSH: begin
        if (dsel < CW'(bpa_pkg::MAX_FRAMES)) begin
          st_wr.en   = 1'b1;
          st_wr.addr = bpa_pkg::st_addr(ord_r, dsel[FW-1:0]);
          st_wr.data = head_r;
          d_we       = 1'b1;
          d_wdata    = dsel + CW'(1);
        end
        cnt_nxt       = '0;
        mark_base_nxt = head_r;
        mark_n_nxt    = CW'(1) << ord_r;
        mark_ord_nxt  = ord_r;
        mark_used_nxt = 1'b0;
        mark_refs_nxt = '0;
        mark_last_nxt = 1'b1;
        status_nxt    = bpa_pkg::ST_OK;
        res_frame_nxt = head_r;
        res_ord_nxt   = ord_r;
        state_nxt     = S_MARK;
      end

      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration write restarts the rebuild
    if (cfg_wr_en) begin
      case (cfg_index)
        bpa_pkg::CFG_FRAME_COUNT:  fc_nxt = cfg_wr_data;
        bpa_pkg::CFG_ORDER_LEVELS: ol_nxt = cfg_wr_data[OW-1:0];
        default: ;
      endcase
      state_nxt   = S_INIT;
      cnt_nxt     = '0;
      blk_end_nxt = '0;
      depth_clr   = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      blk_end_r   <= '0;
      fc_r        <= CW'(1024);
      ol_r        <= OW'(11);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      blk_end_r   <= blk_end_nxt;
      fc_r        <= fc_nxt;
      ol_r        <= ol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    req_r       <= req_nxt;
    fr_r        <= fr_nxt;
    head_r      <= head_nxt;
    ord_r       <= ord_nxt;
    s_r         <= s_nxt;
    buddy_r     <= buddy_nxt;
    mark_base_r <= mark_base_nxt;
    mark_n_r    <= mark_n_nxt;
    mark_ord_r  <= mark_ord_nxt;
    mark_used_r <= mark_used_nxt;
    mark_refs_r <= mark_refs_nxt;
    mark_last_r <= mark_last_nxt;
    status_r    <= status_nxt;
    res_frame_r <= res_frame_nxt;
    res_ord_r   <= res_ord_nxt;
    blk_ord_r   <= blk_ord_nxt;
  end

  // per-order stack depths
  always_ff @(posedge clk) begin
    if (!rst_n || depth_clr) begin
      for (int k = 0; k < bpa_pkg::MAX_ORDERS; k++) depth_r[k] <= '0;
    end else if (d_we) begin
      depth_r[d_idx] <= d_wdata;
    end
  end

  // result beat
  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_frame = res_frame_r;
  assign out_result_order = res_ord_r;

endmodule
